>>> rtl/nfi_pkg.sv
// ----------------------------------------------------------------------------
// nfi_pkg: shared types and constants of the NAL frame indexer
// Field widths, NAL type codes, start code word, register indexes and resets.
// ----------------------------------------------------------------------------
package nfi_pkg;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned STEP_W   = 16;
  localparam int unsigned FRAME_W  = 20;
  localparam int unsigned POS_W    = 32;
  localparam int unsigned STAMP_W  = 32;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 20;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_STAMP_STEP  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LIMIT = 1'd1;

  // Configuration reset values
  localparam logic [STEP_W-1:0]  STAMP_STEP_RESET  = 16'd3600;
  localparam logic [FRAME_W-1:0] FRAME_LIMIT_RESET = FRAME_W'(40 * 60 * 30);

  // Start code and NAL header decoding
  localparam logic [POS_W-1:0] START_CODE_WORD = 32'h0000_0001;
  localparam int unsigned      NAL_TYPE_W      = 5;
  localparam logic [NAL_TYPE_W-1:0] NAL_SPS    = 5'd7;
  localparam logic [NAL_TYPE_W-1:0] NAL_IDR    = 5'd5;
  localparam logic [NAL_TYPE_W-1:0] NAL_SLICE  = 5'd1;

  localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

  // One frame record
  typedef struct packed {
    logic [FRAME_W-1:0] frame_number;
    logic [POS_W-1:0]   frame_start;
    logic [POS_W-1:0]   frame_length;
    logic               intra_frame;
    logic [STAMP_W-1:0] stamp;
    logic               final_record;
  } record_t;

endpackage

>>> rtl/nfi_in_if.sv
// ----------------------------------------------------------------------------
// nfi_in_if: byte stream channel
// Valid/ready channel carrying one stream byte and its end-of-stream mark.
// ----------------------------------------------------------------------------
interface nfi_in_if;
  logic                      valid;
  logic                      ready;
  logic [nfi_pkg::BYTE_W-1:0] data_byte;
  logic                      end_of_stream;

  modport source (output valid, output data_byte, output end_of_stream, input ready);
  modport sink   (input valid, input data_byte, input end_of_stream, output ready);
endinterface

>>> rtl/nfi_out_if.sv
// ----------------------------------------------------------------------------
// nfi_out_if: frame record channel
// Valid/ready channel carrying one frame record.
// ----------------------------------------------------------------------------
interface nfi_out_if;
  logic                        valid;
  logic                        ready;
  logic [nfi_pkg::FRAME_W-1:0] frame_number;
  logic [nfi_pkg::POS_W-1:0]   frame_start;
  logic [nfi_pkg::POS_W-1:0]   frame_length;
  logic                        intra_frame;
  logic [nfi_pkg::STAMP_W-1:0] stamp;
  logic                        final_record;

  modport source (output valid, output frame_number, output frame_start,
                  output frame_length, output intra_frame, output stamp,
                  output final_record, input ready);
  modport sink   (input valid, input frame_number, input frame_start,
                  input frame_length, input intra_frame, input stamp,
                  input final_record, output ready);
endinterface

>>> rtl/nal_frame_indexer_unit.sv
// An accepted byte is held in the input register; its record is then loaded into the record register.
// Throughput: one byte per clock; the input register and the record register
// hold one request each, so a stalled record only blocks once both are full.
// Reset (rst_n low, synchronous): stamp_step = 3600, frame_limit = 72000,
// all stream state zero, both stages empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
// nal_frame_indexer_unit: Annex B start code frame indexer
// Scans a byte stream for 00 00 00 01, decodes the NAL type, opens frames and
// reports one record per closed frame, with the last one marked at stream end.
// ----------------------------------------------------------------------------
module nal_frame_indexer_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  nfi_in_if.sink                           in_ch,
  nfi_out_if.source                        out_ch,
  input  logic                             cfg_wr_en,
  input  logic [nfi_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [nfi_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // Configuration registers
  logic [nfi_pkg::STEP_W-1:0]  stamp_step_r;
  logic [nfi_pkg::FRAME_W-1:0] frame_limit_r;

  // Input stage
  logic                        s1_valid_r;
  logic [nfi_pkg::BYTE_W-1:0]  s1_byte_r;
  logic                        s1_eos_r;

  // Stream state
  logic [nfi_pkg::POS_W-1:0]   window_r,     window_nxt;
  logic [nfi_pkg::POS_W-1:0]   pos_r,        pos_nxt;
  logic                        sps_r,        sps_nxt;
  logic [nfi_pkg::FRAME_W-1:0] found_r,      found_nxt;
  logic [nfi_pkg::POS_W-1:0]   open_start_r, open_start_nxt;
  logic                        open_intra_r, open_intra_nxt;
  logic [nfi_pkg::STAMP_W-1:0] stamp_r,      stamp_nxt;

  // Record register
  logic                        out_valid_r;
  nfi_pkg::record_t            rec_r, rec_nxt;

  logic [nfi_pkg::NAL_TYPE_W-1:0] nal;
  logic                        is_sc;
  logic                        accept;
  logic                        open_frame;
  logic [nfi_pkg::POS_W-1:0]   start_pos;
  logic [nfi_pkg::POS_W-1:0]   pos_inc;
  logic [nfi_pkg::POS_W-1:0]   rec_end;
  logic                        emit;
  logic                        out_free;
  logic                        s1_go;

  // Decode the header byte that follows a start code
  always_comb begin
    nal        = s1_byte_r[nfi_pkg::NAL_TYPE_W-1:0];
    is_sc      = !s1_eos_r && (window_r == nfi_pkg::START_CODE_WORD);
    sps_nxt    = sps_r | (is_sc && (nal == nfi_pkg::NAL_SPS));
    if (sps_nxt) begin
      accept = (nal == nfi_pkg::NAL_SPS) || (nal == nfi_pkg::NAL_SLICE);
    end else begin
      accept = (nal == nfi_pkg::NAL_IDR) || (nal == nfi_pkg::NAL_SLICE);
    end
    open_frame = is_sc && accept && (found_r < frame_limit_r);
    start_pos  = (pos_r == nfi_pkg::POS_MAX) ? nfi_pkg::POS_MAX : pos_r - 32'd4;
    pos_inc    = (pos_r == nfi_pkg::POS_MAX) ? nfi_pkg::POS_MAX : pos_r + 32'd1;
  end

  // Build the record of the frame being closed
  always_comb begin
    emit    = (found_r != '0) && (open_frame || s1_eos_r);
    rec_end = s1_eos_r ? pos_inc : start_pos;
    rec_nxt.frame_number = found_r - 20'd1;
    rec_nxt.frame_start  = open_start_r;
    rec_nxt.frame_length = rec_end - open_start_r;
    rec_nxt.intra_frame  = open_intra_r;
    rec_nxt.stamp        = stamp_r;
    rec_nxt.final_record = s1_eos_r;
  end

  // Advance the input stage when its record has room or the byte emits no record
  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_go       = s1_valid_r && (out_free || !emit);
  assign in_ch.ready = !s1_valid_r || s1_go;

  // Next stream state
  always_comb begin
    window_nxt     = {window_r[nfi_pkg::POS_W-nfi_pkg::BYTE_W-1:0], s1_byte_r};
    pos_nxt        = pos_inc;
    found_nxt      = found_r;
    open_start_nxt = open_start_r;
    open_intra_nxt = open_intra_r;
    stamp_nxt      = stamp_r;
    if (open_frame) begin
      found_nxt      = found_r + 20'd1;
      open_start_nxt = start_pos;
      open_intra_nxt = (nal == nfi_pkg::NAL_SPS) || (nal == nfi_pkg::NAL_IDR);
      stamp_nxt      = stamp_r + {{(nfi_pkg::STAMP_W-nfi_pkg::STEP_W){1'b0}}, stamp_step_r};
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stamp_step_r  <= nfi_pkg::STAMP_STEP_RESET;
      frame_limit_r <= nfi_pkg::FRAME_LIMIT_RESET;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        nfi_pkg::CFG_STAMP_STEP:  stamp_step_r  <= cfg_wdata[nfi_pkg::STEP_W-1:0];
        nfi_pkg::CFG_FRAME_LIMIT: frame_limit_r <= cfg_wdata[nfi_pkg::FRAME_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte_r <= in_ch.data_byte;
      s1_eos_r  <= in_ch.end_of_stream;
    end
  end

  // Stream state; drop it all at the end of the stream
  always_ff @(posedge clk) begin
    if (!rst_n || (s1_go && s1_eos_r)) begin
      window_r     <= '0;
      pos_r        <= '0;
      sps_r        <= 1'b0;
      found_r      <= '0;
      open_start_r <= '0;
      open_intra_r <= 1'b0;
      stamp_r      <= '0;
    end else if (s1_go) begin
      window_r     <= window_nxt;
      pos_r        <= pos_nxt;
      sps_r        <= sps_nxt;
      found_r      <= found_nxt;
      open_start_r <= open_start_nxt;
      open_intra_r <= open_intra_nxt;
      stamp_r      <= stamp_nxt;
    end
  end

  // Record register: load on emit, hold while stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && emit) begin
      rec_r <= rec_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.frame_number = rec_r.frame_number;
  assign out_ch.frame_start  = rec_r.frame_start;
  assign out_ch.frame_length = rec_r.frame_length;
  assign out_ch.intra_frame  = rec_r.intra_frame;
  assign out_ch.stamp        = rec_r.stamp;
  assign out_ch.final_record = rec_r.final_record;

  // The end-of-stream byte leaves a fresh stream behind
  a_eos_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_eos_r) |=> (pos_r == '0 && found_r == '0 && !sps_r))
    else $error("stream state not cleared after end of stream");

  // The byte counter only moves forward inside a stream
  a_pos_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && !s1_eos_r) |=> (pos_r >= $past(pos_r)))
    else $error("byte position went backward");

  // A pending record is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && emit) |-> (!out_valid_r || out_ch.ready))
    else $error("record register overwritten while stalled");

  // Backpressure only comes from a held input stage
  a_ready_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without a full pipeline");

endmodule

>>> tb/sv/tb_nal_frame_indexer_unit.sv
// ----------------------------------------------------------------------------
// tb_nal_frame_indexer_unit: self-checking bench for the NAL frame indexer
// Feeds Annex B byte streams with random gaps and stalls on both channels,
// tracks start codes, NAL types and frame records in a local predictor, and
// checks every frame record field by field against it.
// ----------------------------------------------------------------------------
module tb_nal_frame_indexer_unit;
  import nfi_pkg::*;

  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned DRAIN_CYCLES    = 6;
  localparam int unsigned QUIET_LIMIT     = 3000;

  typedef struct packed {
    logic [BYTE_W-1:0] value;
    logic              last;
  } stream_byte_t;

  logic clk;
  logic rst_n;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  nfi_in_if  in_ch ();
  nfi_out_if out_ch ();

  nal_frame_indexer_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Stimulus and expectation stores
  stream_byte_t bytes_pending[$];
  record_t      records_due[$];
  int unsigned  mismatch_count;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;
  logic         hold_off_arm;
  int unsigned  hold_off_count;
  int unsigned  quiet_cycles;

  // Predictor copy of the registers and the stream state
  logic [STEP_W-1:0]  step_now;
  logic [FRAME_W-1:0] limit_now;
  logic [POS_W-1:0]   scan_window;
  logic [POS_W-1:0]   stream_pos;
  logic               sps_found;
  logic [FRAME_W-1:0] frames_opened;
  logic [POS_W-1:0]   open_start;
  logic               open_intra;
  logic [STAMP_W-1:0] frame_stamp;

  always #1 clk = ~clk;

  task automatic clear_stream_state();
    scan_window   = '0;
    stream_pos    = '0;
    sps_found     = 1'b0;
    frames_opened = '0;
    open_start    = '0;
    open_intra    = 1'b0;
    frame_stamp   = '0;
  endtask

  function automatic record_t close_record(input logic [POS_W-1:0] end_pos, input logic last);
    record_t rec;
    rec.frame_number = frames_opened - 20'd1;
    rec.frame_start  = open_start;
    rec.frame_length = end_pos - open_start;
    rec.intra_frame  = open_intra;
    rec.stamp        = frame_stamp;
    rec.final_record = last;
    return rec;
  endfunction

  // Advance the stream state by one byte and queue the record it closes
  task automatic index_byte(input logic [BYTE_W-1:0] b, input logic eos);
    logic [NAL_TYPE_W-1:0] nal;
    logic                  opens;
    logic [POS_W-1:0]      start_pos;
    if (!eos && scan_window == START_CODE_WORD) begin
      nal = b[NAL_TYPE_W-1:0];
      if (nal == NAL_SPS) begin
        sps_found = 1'b1;
      end
      opens = sps_found ? (nal == NAL_SPS || nal == NAL_SLICE)
                        : (nal == NAL_IDR || nal == NAL_SLICE);
      if (opens && frames_opened < limit_now) begin
        start_pos = (stream_pos == POS_MAX) ? POS_MAX : stream_pos - 32'd4;
        if (frames_opened != '0) begin
          records_due.push_back(close_record(start_pos, 1'b0));
        end
        open_start    = start_pos;
        open_intra    = (nal == NAL_SPS || nal == NAL_IDR);
        frame_stamp   = frame_stamp + {{(STAMP_W-STEP_W){1'b0}}, step_now};
        frames_opened = frames_opened + 20'd1;
      end
    end
    scan_window = {scan_window[POS_W-BYTE_W-1:0], b};
    if (stream_pos != POS_MAX) begin
      stream_pos = stream_pos + 32'd1;
    end
    // Close the last frame and start a fresh stream
    if (eos) begin
      if (frames_opened != '0) begin
        records_due.push_back(close_record(stream_pos, 1'b1));
      end
      clear_stream_state();
    end
  endtask

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatch_count++;
  endtask

  function automatic logic [BYTE_W-1:0] payload_byte();
    return ($urandom_range(3) == 0) ? 8'h00 : BYTE_W'($urandom_range(255));
  endfunction

  function automatic logic [BYTE_W-1:0] nal_header();
    logic [NAL_TYPE_W-1:0] kind;
    case ($urandom_range(9))
      0, 1, 2: kind = NAL_SLICE;
      3, 4:    kind = NAL_IDR;
      5:       kind = NAL_SPS;
      default: kind = NAL_TYPE_W'($urandom_range(31));
    endcase
    return {3'($urandom_range(7)), kind};
  endfunction

  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic eos);
    stream_byte_t item;
    item.value = b;
    item.last  = eos;
    bytes_pending.push_back(item);
  endtask

  task automatic push_start_code();
    repeat (3) push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0);
  endtask

  // Build whole streams of NAL units with random content, some noise mixed in
  task automatic queue_streams(input int unsigned n_bytes);
    int unsigned goal;
    goal = bytes_pending.size() + n_bytes;
    while (bytes_pending.size() < goal) begin
      repeat ($urandom_range(1, 8)) begin
        case ($urandom_range(19))
          0: begin
            repeat ($urandom_range(1, 10)) push_byte(payload_byte(), 1'b0);
          end
          1: begin
            // three-byte code: only counts when a zero precedes it
            push_byte(8'h00, 1'b0);
            push_byte(8'h00, 1'b0);
            push_byte(8'h01, 1'b0);
            push_byte(nal_header(), 1'b0);
          end
          default: begin
            if ($urandom_range(9) == 0) begin
              repeat ($urandom_range(1, 3)) push_byte(8'h00, 1'b0);
            end
            push_start_code();
            push_byte(nal_header(), 1'b0);
            repeat ($urandom_range(8)) push_byte(payload_byte(), 1'b0);
          end
        endcase
      end
      // End the stream, sometimes right on a NAL header
      if ($urandom_range(9) == 0) begin
        push_start_code();
        push_byte(nal_header(), 1'b1);
      end else begin
        push_byte(payload_byte(), 1'b1);
      end
    end
  endtask

  // Directed opening: empty stream, then IDR, slice, SPS, IDR after SPS,
  // and a header on the final byte
  task automatic queue_opening();
    logic [BYTE_W-1:0] seq [26];
    seq = '{8'h00,
            8'h00, 8'h00, 8'h00, 8'h01, 8'h65,
            8'h00, 8'h00, 8'h00, 8'h01, 8'h41,
            8'h00, 8'h00, 8'h00, 8'h01, 8'h67,
            8'h00, 8'h00, 8'h00, 8'h01, 8'h25,
            8'h00, 8'h00, 8'h00, 8'h01, 8'hE1};
    for (int i = 0; i < 26; i++) begin
      push_byte(seq[i], (i == 0 || i == 25));
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_STAMP_STEP) begin
      step_now = val[STEP_W-1:0];
    end else begin
      limit_now = val[FRAME_W-1:0];
    end
  endtask

  // Wait until every request is through and every record is back
  task automatic settle();
    do @(negedge clk);
    while (bytes_pending.size() != 0 || in_ch.valid || records_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input logic [STEP_W-1:0] step, input logic [FRAME_W-1:0] limit,
                           input int unsigned n_bytes, input int unsigned s_idle,
                           input int unsigned r_idle, input logic arm);
    write_reg(CFG_STAMP_STEP, CFG_DATA_W'(step));
    write_reg(CFG_FRAME_LIMIT, limit);
    @(negedge clk);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    if (arm) begin
      hold_off_arm = 1'b1;
    end
    queue_streams(n_bytes);
    settle();
  endtask

  // Drive byte requests from the pending queue
  always @(posedge clk) begin : drive_bytes
    stream_byte_t next_byte;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        index_byte(in_ch.data_byte, in_ch.end_of_stream);
      end
      if (!(in_ch.valid && !in_ch.ready)) begin
        if (bytes_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_byte = bytes_pending.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.data_byte     <= next_byte.value;
          in_ch.end_of_stream <= next_byte.last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Take frame records, check them, and pace ready
  always @(posedge clk) begin : take_records
    record_t got;
    record_t want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got.frame_number = out_ch.frame_number;
        got.frame_start  = out_ch.frame_start;
        got.frame_length = out_ch.frame_length;
        got.intra_frame  = out_ch.intra_frame;
        got.stamp        = out_ch.stamp;
        got.final_record = out_ch.final_record;
        if (records_due.size() == 0) begin
          flag_mismatch($sformatf("record for frame %0d with none expected",
                                  got.frame_number));
        end else begin
          want = records_due.pop_front();
          if (got.frame_number !== want.frame_number)
            flag_mismatch($sformatf("frame_number got %0d want %0d",
                                    got.frame_number, want.frame_number));
          if (got.frame_start !== want.frame_start)
            flag_mismatch($sformatf("frame_start got %0d want %0d",
                                    got.frame_start, want.frame_start));
          if (got.frame_length !== want.frame_length)
            flag_mismatch($sformatf("frame_length got %0d want %0d",
                                    got.frame_length, want.frame_length));
          if (got.intra_frame !== want.intra_frame)
            flag_mismatch($sformatf("intra_frame got %0b want %0b",
                                    got.intra_frame, want.intra_frame));
          if (got.stamp !== want.stamp)
            flag_mismatch($sformatf("stamp got %0d want %0d", got.stamp, want.stamp));
          if (got.final_record !== want.final_record)
            flag_mismatch($sformatf("final_record got %0b want %0b",
                                    got.final_record, want.final_record));
        end
      end
      // Hold off once for a long stretch after a record shows up
      if (hold_off_arm && hold_off_count < HOLD_OFF_CYCLES &&
          (hold_off_count != 0 || out_ch.valid)) begin
        hold_off_count++;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Stop a run in which nothing moves
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.data_byte     = '0;
    in_ch.end_of_stream = 1'b0;
    out_ch.ready        = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_index           = CFG_STAMP_STEP;
    cfg_wdata           = '0;
    mismatch_count      = 0;
    send_idle_pct       = 19;
    recv_idle_pct       = 57;
    hold_off_arm        = 1'b0;
    hold_off_count      = 0;
    quiet_cycles        = 0;
    step_now            = STAMP_STEP_RESET;
    limit_now           = FRAME_LIMIT_RESET;
    clear_stream_state();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed streams at the reset settings
    @(negedge clk);
    queue_opening();
    settle();

    // Random streams across register settings and idling patterns
    run_phase(16'hFFFF, 20'hFFFFF, 400, 19, 57, 1'b1);
    run_phase(16'h0000, 20'd1, 200, 19, 57, 1'b0);
    run_phase(STEP_W'($urandom_range(65535)), 20'd3, 300, 57, 19, 1'b0);
    run_phase(16'd1, FRAME_W'($urandom_range(2, 8)), 300, 57, 19, 1'b0);
    run_phase(STAMP_STEP_RESET, FRAME_LIMIT_RESET, 400, 0, 0, 1'b0);

    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
